// File: sv/php_pkg.sv
// Shared types, codes and constants of the packet header parser.
package php_pkg;

  typedef enum logic [1:0] {
    NK_NONE = 2'd0,
    NK_IPV4 = 2'd1,
    NK_ARP  = 2'd2,
    NK_IPV6 = 2'd3
  } net_kind_t;

  typedef enum logic [2:0] {
    TK_NONE = 3'd0,
    TK_ICMP = 3'd1,
    TK_TCP  = 3'd2,
    TK_UDP  = 3'd3,
    TK_IGMP = 3'd4
  } transport_kind_t;

  typedef enum logic [2:0] {
    AK_NONE  = 3'd0,
    AK_HTTP  = 3'd1,
    AK_FTP   = 3'd2,
    AK_HTTPS = 3'd3,
    AK_DNS   = 3'd4
  } app_kind_t;

  // Ethernet types
  localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETH_TYPE_ARP  = 16'h0806;
  localparam logic [15:0] ETH_TYPE_RARP = 16'h8035;
  localparam logic [15:0] ETH_TYPE_IPV6 = 16'h86DD;

  // Layer-4 protocol numbers
  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_IGMP = 8'd2;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  // Well-known ports
  localparam logic [15:0] PORT_HTTP  = 16'd80;
  localparam logic [15:0] PORT_FTP   = 16'd21;
  localparam logic [15:0] PORT_HTTPS = 16'd443;
  localparam logic [15:0] PORT_DNS   = 16'd53;

  // Frame positions (byte offsets from the destination address)
  localparam int unsigned POS_W = 8;
  localparam logic [POS_W-1:0] POS_TYPE_HI    = 8'd12;
  localparam logic [POS_W-1:0] POS_TYPE_LO    = 8'd13;
  localparam logic [POS_W-1:0] POS_L3         = 8'd14;
  localparam logic [POS_W-1:0] POS_LIMIT      = 8'd128;
  localparam logic [POS_W-1:0] POS_V4_PROTO   = 8'd23;
  localparam logic [POS_W-1:0] POS_V4_SRC     = 8'd26;
  localparam logic [POS_W-1:0] POS_V4_DST     = 8'd30;
  localparam logic [POS_W-1:0] POS_V4_END     = 8'd34;
  localparam logic [POS_W-1:0] POS_V6_NEXT    = 8'd20;
  localparam logic [POS_W-1:0] POS_V6_SRC_HI  = 8'd22;
  localparam logic [POS_W-1:0] POS_V6_SRC_LO  = 8'd30;
  localparam logic [POS_W-1:0] POS_V6_DST_HI  = 8'd38;
  localparam logic [POS_W-1:0] POS_V6_DST_LO  = 8'd46;
  localparam logic [POS_W-1:0] POS_V6_END     = 8'd54;
  localparam logic [POS_W-1:0] POS_ARP_SPA    = 8'd28;
  localparam logic [POS_W-1:0] POS_ARP_SPA_END = 8'd32;
  localparam logic [POS_W-1:0] POS_ARP_TPA    = 8'd38;
  localparam logic [POS_W-1:0] POS_ARP_TPA_END = 8'd42;
  localparam logic [POS_W-1:0] POS_MAX        = 8'd255;

  localparam logic [6:0] L4_START_IPV6 = 7'd54;
  localparam logic [6:0] L4_START_IPV4 = 7'd14;

  // Offsets inside the layer-4 header
  localparam logic [POS_W-1:0] L4_DPORT = 8'd2;
  localparam logic [POS_W-1:0] L4_SEQ   = 8'd4;
  localparam logic [POS_W-1:0] L4_ACK   = 8'd8;
  localparam logic [POS_W-1:0] L4_ACK_END = 8'd12;
  localparam logic [POS_W-1:0] L4_FLAGS = 8'd13;
  localparam logic [POS_W-1:0] L4_LEN   = 8'd14;

  // TCP flag bits in the flags byte
  localparam int unsigned TCP_BIT_ACK = 4;
  localparam int unsigned TCP_BIT_SYN = 1;
  localparam int unsigned TCP_BIT_FIN = 0;

  // One byte handed to the capture unit
  typedef struct packed {
    logic       step;
    logic [7:0] data;
    logic       last;
  } php_beat_t;

  // Everything captured for one frame
  typedef struct packed {
    net_kind_t       net_kind;
    transport_kind_t transport_kind;
    logic [6:0]      l4_start;
    logic [7:0]      type_hi;
    logic [63:0]     src_hi;
    logic [63:0]     src_lo;
    logic [63:0]     dst_hi;
    logic [63:0]     dst_lo;
    logic [15:0]     src_port;
    logic [15:0]     dst_port;
    logic [31:0]     seq_num;
    logic [31:0]     ack_num;
    logic [2:0]      flags;
  } php_frame_t;

  function automatic transport_kind_t proto_to_kind(input logic [7:0] p);
    transport_kind_t k;
    case (p)
      PROTO_ICMP: k = TK_ICMP;
      PROTO_TCP:  k = TK_TCP;
      PROTO_UDP:  k = TK_UDP;
      PROTO_IGMP: k = TK_IGMP;
      default:    k = TK_NONE;
    endcase
    return k;
  endfunction

endpackage

// File: sv/php_if.sv
// Valid/ready channel interfaces of the packet header parser.
interface php_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface php_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  net_kind;
  logic [2:0]  transport_kind;
  logic [2:0]  app_kind;
  logic [63:0] src_addr_hi;
  logic [63:0] src_addr_lo;
  logic [63:0] dst_addr_hi;
  logic [63:0] dst_addr_lo;
  logic [15:0] src_port;
  logic [15:0] dst_port;
  logic [31:0] seq_num;
  logic [31:0] ack_num;
  logic [2:0]  tcp_flags;

  modport source (output valid, net_kind, transport_kind, app_kind, src_addr_hi, src_addr_lo,
                  dst_addr_hi, dst_addr_lo, src_port, dst_port, seq_num, ack_num,
                  tcp_flags, input ready);
  modport sink   (input valid, net_kind, transport_kind, app_kind, src_addr_hi, src_addr_lo,
                  dst_addr_hi, dst_addr_lo, src_port, dst_port, seq_num, ack_num,
                  tcp_flags, output ready);
endinterface

// File: sv/php_capture.sv
// Per-frame byte position and field capture registers of the header parser.
module php_capture
  import php_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  php_beat_t  beat,
  output php_frame_t frame_nxt
);

  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] pos_nxt;
  php_frame_t       frame_r;
  logic [POS_W-1:0] l4_rel;
  logic             l4_hit;

  always_comb begin
    // Position zero starts a new frame: everything captured is dropped first.
    frame_nxt = (pos_r == '0) ? '0 : frame_r;
    l4_rel    = '0;
    l4_hit    = 1'b0;

    if (pos_r == POS_TYPE_HI) begin
      frame_nxt.type_hi = beat.data;
    end else if (pos_r == POS_TYPE_LO) begin
      case ({frame_nxt.type_hi, beat.data})
        ETH_TYPE_IPV4: frame_nxt.net_kind = NK_IPV4;
        ETH_TYPE_ARP,
        ETH_TYPE_RARP: frame_nxt.net_kind = NK_ARP;
        ETH_TYPE_IPV6: begin
          frame_nxt.net_kind = NK_IPV6;
          frame_nxt.l4_start = L4_START_IPV6;
        end
        default:       frame_nxt.net_kind = NK_NONE;
      endcase
    end else if (pos_r >= POS_L3 && pos_r < POS_LIMIT) begin
      case (frame_nxt.net_kind)
        NK_IPV4: begin
          if (pos_r == POS_L3) begin
            frame_nxt.l4_start = L4_START_IPV4 + {1'b0, beat.data[3:0], 2'b00};
          end
          if (pos_r == POS_V4_PROTO) begin
            frame_nxt.transport_kind = proto_to_kind(beat.data);
          end
          if (pos_r >= POS_V4_SRC && pos_r < POS_V4_DST) begin
            frame_nxt.src_lo = {frame_nxt.src_lo[55:0], beat.data};
          end
          if (pos_r >= POS_V4_DST && pos_r < POS_V4_END) begin
            frame_nxt.dst_lo = {frame_nxt.dst_lo[55:0], beat.data};
          end
        end
        NK_IPV6: begin
          if (pos_r == POS_V6_NEXT) begin
            frame_nxt.transport_kind = proto_to_kind(beat.data);
          end
          if (pos_r >= POS_V6_SRC_HI && pos_r < POS_V6_SRC_LO) begin
            frame_nxt.src_hi = {frame_nxt.src_hi[55:0], beat.data};
          end else if (pos_r >= POS_V6_SRC_LO && pos_r < POS_V6_DST_HI) begin
            frame_nxt.src_lo = {frame_nxt.src_lo[55:0], beat.data};
          end else if (pos_r >= POS_V6_DST_HI && pos_r < POS_V6_DST_LO) begin
            frame_nxt.dst_hi = {frame_nxt.dst_hi[55:0], beat.data};
          end else if (pos_r >= POS_V6_DST_LO && pos_r < POS_V6_END) begin
            frame_nxt.dst_lo = {frame_nxt.dst_lo[55:0], beat.data};
          end
        end
        NK_ARP: begin
          if (pos_r >= POS_ARP_SPA && pos_r < POS_ARP_SPA_END) begin
            frame_nxt.src_lo = {frame_nxt.src_lo[55:0], beat.data};
          end
          if (pos_r >= POS_ARP_TPA && pos_r < POS_ARP_TPA_END) begin
            frame_nxt.dst_lo = {frame_nxt.dst_lo[55:0], beat.data};
          end
        end
        default: ;
      endcase

      // The layer-4 window uses the start just computed, so a zero IHL
      // places byte 14 in both the IPv4 header and the layer-4 header.
      l4_rel = pos_r - {1'b0, frame_nxt.l4_start};
      l4_hit = (frame_nxt.net_kind == NK_IPV4 || frame_nxt.net_kind == NK_IPV6) &&
               (pos_r >= {1'b0, frame_nxt.l4_start}) && (l4_rel < L4_LEN);
      if (l4_hit) begin
        if (l4_rel < L4_DPORT) begin
          frame_nxt.src_port = {frame_nxt.src_port[7:0], beat.data};
        end else if (l4_rel < L4_SEQ) begin
          frame_nxt.dst_port = {frame_nxt.dst_port[7:0], beat.data};
        end else if (l4_rel < L4_ACK) begin
          frame_nxt.seq_num = {frame_nxt.seq_num[23:0], beat.data};
        end else if (l4_rel < L4_ACK_END) begin
          frame_nxt.ack_num = {frame_nxt.ack_num[23:0], beat.data};
        end else if (l4_rel == L4_FLAGS) begin
          frame_nxt.flags = {beat.data[TCP_BIT_ACK], beat.data[TCP_BIT_SYN],
                             beat.data[TCP_BIT_FIN]};
        end
      end
    end
  end

  // Every position from 128 on behaves the same, so the count saturates early.
  always_comb begin
    if (beat.last) begin
      pos_nxt = '0;
    end else if (pos_r != POS_MAX) begin
      pos_nxt = pos_r + 1'b1;
    end else begin
      pos_nxt = pos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      frame_r <= '0;
    end else if (beat.step) begin
      pos_r   <= pos_nxt;
      frame_r <= frame_nxt;
    end
  end

endmodule

// File: sv/packet_header_parser.sv
// Top level of the packet header parser: input register, capture unit and result register.
//
// The parser takes an Ethernet frame one byte per transfer on the input channel, starting
// at the destination address, with last_byte marking the final byte. It recognises IPv4,
// ARP and RARP (both reported as ARP) and IPv6 from the Ethernet type, finds the layer-4
// header from the IPv4 header length or at a fixed 40 bytes into an IPv6 header, and
// captures addresses, ports, TCP sequence and acknowledge numbers and the ACK, SYN and FIN
// flags. Exactly one summary transfer leaves on the output channel for each frame, built
// from the state after the last byte has been taken; frames that stop early report zero
// for every field they never reached. Each byte waits in the input register and is folded
// into the capture registers as it leaves, so the block sustains one byte per clock unless
// a last byte is held back. The summary is written into the result register at the edge at
// which the last byte leaves the input register, so it reaches the output channel through
// the input register and then the result register. Only a last byte waits for the result
// register, so a stalled output channel holds up the input just once a frame, and only
// until the previous summary has been taken.
module packet_header_parser
  import php_pkg::*;
(
  input logic   clk,
  input logic   rst_n,
  php_in_if.sink    in_chan,
  php_out_if.source out_chan
);

  typedef struct packed {
    net_kind_t       net_kind;
    transport_kind_t transport_kind;
    app_kind_t       app_kind;
    logic [63:0]     src_hi;
    logic [63:0]     src_lo;
    logic [63:0]     dst_hi;
    logic [63:0]     dst_lo;
    logic [15:0]     src_port;
    logic [15:0]     dst_port;
    logic [31:0]     seq_num;
    logic [31:0]     ack_num;
    logic [2:0]      flags;
  } php_result_t;

  // Input register stage
  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_last_r;

  // Result register stage
  logic        out_valid_r;
  php_result_t result_r;
  php_result_t result_nxt;

  logic        out_free;
  logic        s1_fire;
  logic        in_fire;
  php_beat_t   beat;
  php_frame_t  frame_nxt;
  logic        is_tcp;
  logic        has_ports;

  // The result register can take a new summary when it is empty or is being drained.
  assign out_free = !out_valid_r || out_chan.ready;
  // Non-last bytes never wait; a last byte needs room for its summary.
  assign s1_fire  = s1_valid_r && (!s1_last_r || out_free);
  assign in_chan.ready = !s1_valid_r || s1_fire;
  assign in_fire  = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_chan.data_byte;
      s1_last_r <= in_chan.last_byte;
    end
  end

  assign beat = '{step: s1_fire, data: s1_byte_r, last: s1_last_r};

  php_capture u_capture (
    .clk       (clk),
    .rst_n     (rst_n),
    .beat      (beat),
    .frame_nxt (frame_nxt)
  );

  // Summary of the frame as it stands after the byte now leaving the input register.
  assign is_tcp    = (frame_nxt.transport_kind == TK_TCP);
  assign has_ports = is_tcp || (frame_nxt.transport_kind == TK_UDP);

  always_comb begin
    result_nxt.net_kind       = frame_nxt.net_kind;
    result_nxt.transport_kind = frame_nxt.transport_kind;
    result_nxt.src_hi         = frame_nxt.src_hi;
    result_nxt.src_lo         = frame_nxt.src_lo;
    result_nxt.dst_hi         = frame_nxt.dst_hi;
    result_nxt.dst_lo         = frame_nxt.dst_lo;
    result_nxt.src_port       = has_ports ? frame_nxt.src_port : '0;
    result_nxt.dst_port       = has_ports ? frame_nxt.dst_port : '0;
    result_nxt.seq_num        = is_tcp ? frame_nxt.seq_num : '0;
    result_nxt.ack_num        = is_tcp ? frame_nxt.ack_num : '0;
    result_nxt.flags          = is_tcp ? frame_nxt.flags : '0;

    // HTTP wins over FTP, and FTP over HTTPS, whichever side carries the port.
    result_nxt.app_kind = AK_NONE;
    case (frame_nxt.transport_kind)
      TK_TCP: begin
        if (frame_nxt.src_port == PORT_HTTP || frame_nxt.dst_port == PORT_HTTP) begin
          result_nxt.app_kind = AK_HTTP;
        end else if (frame_nxt.src_port == PORT_FTP || frame_nxt.dst_port == PORT_FTP) begin
          result_nxt.app_kind = AK_FTP;
        end else if (frame_nxt.src_port == PORT_HTTPS ||
                     frame_nxt.dst_port == PORT_HTTPS) begin
          result_nxt.app_kind = AK_HTTPS;
        end
      end
      TK_UDP: begin
        if (frame_nxt.src_port == PORT_DNS || frame_nxt.dst_port == PORT_DNS) begin
          result_nxt.app_kind = AK_DNS;
        end
      end
      default: result_nxt.app_kind = AK_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last_r) begin
      result_r <= result_nxt;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.net_kind       = result_r.net_kind;
  assign out_chan.transport_kind = result_r.transport_kind;
  assign out_chan.app_kind       = result_r.app_kind;
  assign out_chan.src_addr_hi    = result_r.src_hi;
  assign out_chan.src_addr_lo    = result_r.src_lo;
  assign out_chan.dst_addr_hi    = result_r.dst_hi;
  assign out_chan.dst_addr_lo    = result_r.dst_lo;
  assign out_chan.src_port       = result_r.src_port;
  assign out_chan.dst_port       = result_r.dst_port;
  assign out_chan.seq_num        = result_r.seq_num;
  assign out_chan.ack_num        = result_r.ack_num;
  assign out_chan.tcp_flags      = result_r.flags;

  // A summary only appears after a last byte has left the input register.
  a_summary_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_fire && s1_last_r))
    else $error("summary raised without a last byte");

  // A last byte is never folded in while an untaken summary would be overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_last_r) |-> (!out_valid_r || out_chan.ready))
    else $error("summary overwritten before transfer");

  // TCP-only fields are zero for any other transport.
  a_tcp_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && result_r.transport_kind != TK_TCP) |->
      (result_r.seq_num == '0 && result_r.ack_num == '0 && result_r.flags == '0))
    else $error("TCP fields set on a non-TCP summary");

  // Without a recognised network layer nothing is ever captured.
  a_no_net_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && result_r.net_kind == NK_NONE) |->
      (result_r.src_lo == '0 && result_r.dst_lo == '0 && result_r.transport_kind == TK_NONE))
    else $error("addresses captured without a network layer");

endmodule

// File: tb/tb_packet_header_parser.sv
`timescale 1ns / 100ps
// Self-checking testbench of the packet header parser: frame stimulus, header predictor and checker.
//
// Frames are pushed into the parser one byte per input transfer. A predictor runs alongside and
// is fed the same bytes in the same order. Each time a last byte is transferred, the predictor
// yields the summary that the parser should report, and that summary joins a queue. Every
// summary transfer on the output channel is then compared field by field with the head of
// that queue.
//
// The run has two parts. A table of directed frames comes first. It covers runt frames,
// every Ethernet type, every transport protocol and well-known port, IHL extremes including
// header lengths below five words, frames cut short before the protocol byte, and one frame
// long enough to saturate the position counter. The random part follows. Most of it is
// well-formed IPv4, IPv6 and ARP headers with random content, mixed with unknown types,
// unknown protocols, truncated frames and overlong frames.
module tb_packet_header_parser
  import php_pkg::*;
();

  localparam int unsigned NUM_DIR      = 26;
  localparam int unsigned RAND_BYTES   = 120;
  localparam int unsigned RAND_FRAMES  = 3;
  localparam int unsigned HOLD_AT      = 10;     // summary index at which the sink holds off
  localparam int unsigned HOLD_CYCLES  = 3000;
  localparam int unsigned STALL_LIMIT  = 20000;  // cycles without any transfer
  localparam int unsigned MAX_REPORTS  = 10;

  // One frame summary, in the order in which the output channel carries its fields.
  typedef struct packed {
    net_kind_t       net_kind;
    transport_kind_t transport_kind;
    app_kind_t       app_kind;
    logic [63:0]     src_hi;
    logic [63:0]     src_lo;
    logic [63:0]     dst_hi;
    logic [63:0]     dst_lo;
    logic [15:0]     src_port;
    logic [15:0]     dst_port;
    logic [31:0]     seq_num;
    logic [31:0]     ack_num;
    logic [2:0]      tcp_flags;
  } summary_t;

  // Recipe of one frame. When typed is set, the expected summary is net_kind = exp_nk and
  // all other fields zero. That is used only where the answer is obvious. A flat frame
  // repeats flat_val in every byte and has no header laid out in it.
  typedef struct packed {
    logic [31:0] len;
    logic        typed;
    net_kind_t   exp_nk;
    logic        steady;
    logic        flat;
    logic [7:0]  flat_val;
    logic [15:0] etype;
    logic [3:0]  ihl;
    logic [7:0]  proto;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [7:0]  flags;
  } frame_recipe_t;

  logic clk;
  logic rst_n;

  php_in_if  in_chan ();
  php_out_if out_chan ();

  packet_header_parser dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // The directed table. Columns: length, typed expectation, expected net kind, no sender gaps,
  // flat fill and its value, Ethernet type, IHL, protocol, ports, sequence, acknowledge, flags.
  frame_recipe_t dir_tab [NUM_DIR] = '{
    // Runt frames and bare Ethernet types: the summary is the net kind alone, or nothing.
    '{32'd1,  1'b1, NK_NONE, 1'b0, 1'b0, 8'h00, ETH_TYPE_IPV4, 4'd5, PROTO_TCP,
      16'd0, 16'd0, 32'd0, 32'd0, 8'h00},
    '{32'd13, 1'b1, NK_NONE, 1'b0, 1'b0, 8'h00, ETH_TYPE_IPV4, 4'd5, PROTO_TCP,
      16'd0, 16'd0, 32'd0, 32'd0, 8'h00},
    '{32'd14, 1'b1, NK_IPV4, 1'b0, 1'b0, 8'h00, ETH_TYPE_IPV4, 4'd5, PROTO_TCP,
      16'd0, 16'd0, 32'd0, 32'd0, 8'h00},
    '{32'd14, 1'b1, NK_ARP,  1'b0, 1'b0, 8'h00, ETH_TYPE_ARP,  4'd5, PROTO_TCP,
      16'd0, 16'd0, 32'd0, 32'd0, 8'h00},
    '{32'd14, 1'b1, NK_ARP,  1'b0, 1'b0, 8'h00, ETH_TYPE_RARP, 4'd5, PROTO_TCP,
      16'd0, 16'd0, 32'd0, 32'd0, 8'h00},
    '{32'd14, 1'b1, NK_IPV6, 1'b0, 1'b0, 8'h00, ETH_TYPE_IPV6, 4'd5, PROTO_TCP,
      16'd0, 16'd0, 32'd0, 32'd0, 8'h00},
    '{32'd14, 1'b1, NK_NONE, 1'b0, 1'b0, 8'h00, 16'hFFFF,      4'd5, PROTO_TCP,
      16'd0, 16'd0, 32'd0, 32'd0, 8'h00},
    // All-zero and all-ones frames carry an unknown type, so nothing is captured.
    '{32'd14, 1'b1, NK_NONE, 1'b0, 1'b1, 8'h00, 16'h0000,      4'd0, 8'h00,
      16'd0, 16'd0, 32'd0, 32'd0, 8'h00},
    '{32'd14, 1'b1, NK_NONE, 1'b0, 1'b1, 8'hFF, 16'hFFFF,      4'd0, 8'h00,
      16'd0, 16'd0, 32'd0, 32'd0, 8'h00},
    // Well-formed IPv4 with every protocol and every application port.
    '{32'd48, 1'b0, NK_NONE, 1'b0, 1'b0, 8'h00, ETH_TYPE_IPV4, 4'd5, PROTO_TCP,
      16'd1234, PORT_HTTP, 32'hFFFF_FFFF, 32'h0000_0000, 8'hFF},
    '{32'd48, 1'b0, NK_NONE, 1'b0, 1'b0, 8'h00, ETH_TYPE_IPV4, 4'd5, PROTO_TCP,
      PORT_FTP, 16'd5000, 32'h1234_5678, 32'h9ABC_DEF0, 8'h12},
    '{32'd48, 1'b0, NK_NONE, 1'b0, 1'b0, 8'h00, ETH_TYPE_IPV4, 4'd5, PROTO_TCP,
      16'd0, PORT_HTTPS, 32'h0000_0001, 32'h8000_0000, 8'h01},
    '{32'd38, 1'b0, NK_NONE, 1'b0, 1'b0, 8'h00, ETH_TYPE_IPV4, 4'd5, PROTO_UDP,
      PORT_DNS, 16'd65535, 32'd0, 32'd0, 8'h00},
    '{32'd38, 1'b0, NK_NONE, 1'b0, 1'b0, 8'h00, ETH_TYPE_IPV4, 4'd5, PROTO_ICMP,
      PORT_HTTP, PORT_HTTP, 32'd7, 32'd9, 8'hFF},
    '{32'd38, 1'b0, NK_NONE, 1'b0, 1'b0, 8'h00, ETH_TYPE_IPV4, 4'd5, PROTO_IGMP,
      PORT_DNS, PORT_DNS, 32'd7, 32'd9, 8'hFF},
    '{32'd38, 1'b0, NK_NONE, 1'b0, 1'b0, 8'h00, ETH_TYPE_IPV4, 4'd5, 8'hFF,
      PORT_HTTP, PORT_HTTP, 32'd7, 32'd9, 8'hFF},
    // IHL at its top, at zero and in the range where the layer-4 header overlaps IPv4 fields.
    '{32'd88, 1'b0, NK_NONE, 1'b0, 1'b0, 8'h00, ETH_TYPE_IPV4, 4'd15, PROTO_TCP,
      16'd65535, PORT_HTTP, 32'hDEAD_BEEF, 32'hFFFF_FFFF, 8'h13},
    '{32'd34, 1'b0, NK_NONE, 1'b0, 1'b0, 8'h00, ETH_TYPE_IPV4, 4'd0, PROTO_TCP,
      PORT_FTP, PORT_HTTPS, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 8'h10},
    '{32'd34, 1'b0, NK_NONE, 1'b0, 1'b0, 8'h00, ETH_TYPE_IPV4, 4'd3, PROTO_UDP,
      16'd999, PORT_DNS, 32'd0, 32'd0, 8'h02},
    // Cut short before the protocol byte: only the net kind is known.
    '{32'd23, 1'b1, NK_IPV4, 1'b0, 1'b0, 8'h00, ETH_TYPE_IPV4, 4'd5, PROTO_TCP,
      PORT_HTTP, PORT_HTTP, 32'd1, 32'd1, 8'h12},
    // IPv6 with TCP, UDP and ICMP, and a full ARP header.
    '{32'd68, 1'b0, NK_NONE, 1'b0, 1'b0, 8'h00, ETH_TYPE_IPV6, 4'd0, PROTO_TCP,
      PORT_HTTP, 16'd0, 32'h0000_0000, 32'hFFFF_FFFF, 8'h13},
    '{32'd58, 1'b0, NK_NONE, 1'b0, 1'b0, 8'h00, ETH_TYPE_IPV6, 4'd0, PROTO_UDP,
      16'd4000, PORT_DNS, 32'd5, 32'd6, 8'h00},
    '{32'd58, 1'b0, NK_NONE, 1'b0, 1'b0, 8'h00, ETH_TYPE_IPV6, 4'd0, PROTO_ICMP,
      PORT_DNS, PORT_DNS, 32'd5, 32'd6, 8'hFF},
    '{32'd42, 1'b0, NK_NONE, 1'b0, 1'b0, 8'h00, ETH_TYPE_ARP,  4'd0, 8'h00,
      16'd0, 16'd0, 32'd0, 32'd0, 8'h00},
    // Long enough to run the position counter into its saturation point. It is sent
    // without gaps to keep the run short.
    '{32'd258, 1'b0, NK_NONE, 1'b1, 1'b0, 8'h00, ETH_TYPE_IPV4, 4'd5, PROTO_TCP,
      16'd3000, PORT_FTP, 32'hCAFE_F00D, 32'h0BAD_CAFE, 8'h11},
    // A runt right after the long frame shows that its capture was cleared.
    '{32'd1,  1'b1, NK_NONE, 1'b0, 1'b0, 8'h00, ETH_TYPE_IPV4, 4'd5, PROTO_TCP,
      16'd0, 16'd0, 32'd0, 32'd0, 8'h00}
  };

  // Predictor state: the header captured so far and the position of the next byte.
  php_frame_t  hdr_state;
  logic [15:0] frame_pos;

  summary_t    summary_q [$];
  logic [7:0]  frame_bytes [$];

  int unsigned idle_cycles = 0;
  int unsigned mismatches = 0;
  int unsigned summaries_checked = 0;
  int unsigned bytes_sent = 0;
  int unsigned frames_sent = 0;
  int unsigned kind_seen [4] = '{0, 0, 0, 0};
  int unsigned tcp_seen = 0;
  int unsigned udp_seen = 0;
  int unsigned app_seen = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Transport kind from a protocol number, as carried in both IPv4 and IPv6 headers.
  function automatic transport_kind_t kind_of_proto(input logic [7:0] p);
    case (p)
      PROTO_ICMP: return TK_ICMP;
      PROTO_TCP:  return TK_TCP;
      PROTO_UDP:  return TK_UDP;
      PROTO_IGMP: return TK_IGMP;
      default:    return TK_NONE;
    endcase
  endfunction

  // Feeds one byte to the predictor. It returns 1 with the frame summary in s when the byte
  // closes the frame.
  function automatic logic parse_byte(input logic [7:0] b, input logic lst, output summary_t s);
    logic [15:0] p;
    logic [15:0] rel;
    logic        l4_ok;
    p = frame_pos;
    s = '0;
    if (p == 16'd0) begin
      hdr_state = '0;
    end
    if (p == 16'(POS_TYPE_HI)) begin
      hdr_state.type_hi = b;
    end else if (p == 16'(POS_TYPE_LO)) begin
      case ({hdr_state.type_hi, b})
        ETH_TYPE_IPV4: hdr_state.net_kind = NK_IPV4;
        ETH_TYPE_ARP, ETH_TYPE_RARP: hdr_state.net_kind = NK_ARP;
        ETH_TYPE_IPV6: begin
          hdr_state.net_kind = NK_IPV6;
          hdr_state.l4_start = 7'd54;
        end
        default: hdr_state.net_kind = NK_NONE;
      endcase
    end else if (p >= 16'(POS_L3) && p < 16'(POS_LIMIT)) begin
      case (hdr_state.net_kind)
        NK_IPV4: begin
          // The IHL is taken before the layer-4 capture below, so an IHL of zero makes
          // this very byte the first byte of the source port.
          if (p == 16'd14) hdr_state.l4_start = 7'd14 + {1'b0, b[3:0], 2'b00};
          if (p == 16'd23) hdr_state.transport_kind = kind_of_proto(b);
          if (p >= 16'd26 && p < 16'd30) hdr_state.src_lo = {hdr_state.src_lo[55:0], b};
          if (p >= 16'd30 && p < 16'd34) hdr_state.dst_lo = {hdr_state.dst_lo[55:0], b};
        end
        NK_IPV6: begin
          if (p == 16'd20) hdr_state.transport_kind = kind_of_proto(b);
          if (p >= 16'd22 && p < 16'd30) hdr_state.src_hi = {hdr_state.src_hi[55:0], b};
          else if (p >= 16'd30 && p < 16'd38) hdr_state.src_lo = {hdr_state.src_lo[55:0], b};
          else if (p >= 16'd38 && p < 16'd46) hdr_state.dst_hi = {hdr_state.dst_hi[55:0], b};
          else if (p >= 16'd46 && p < 16'd54) hdr_state.dst_lo = {hdr_state.dst_lo[55:0], b};
        end
        NK_ARP: begin
          if (p >= 16'd28 && p < 16'd32) hdr_state.src_lo = {hdr_state.src_lo[55:0], b};
          if (p >= 16'd38 && p < 16'd42) hdr_state.dst_lo = {hdr_state.dst_lo[55:0], b};
        end
        default: ;
      endcase
      l4_ok = (hdr_state.net_kind == NK_IPV4 || hdr_state.net_kind == NK_IPV6) &&
              p >= 16'(hdr_state.l4_start);
      rel = p - 16'(hdr_state.l4_start);
      if (l4_ok && rel < 16'd14) begin
        if (rel < 16'd2)       hdr_state.src_port = {hdr_state.src_port[7:0], b};
        else if (rel < 16'd4)  hdr_state.dst_port = {hdr_state.dst_port[7:0], b};
        else if (rel < 16'd8)  hdr_state.seq_num = {hdr_state.seq_num[23:0], b};
        else if (rel < 16'd12) hdr_state.ack_num = {hdr_state.ack_num[23:0], b};
        else if (rel == 16'd13) hdr_state.flags = {b[TCP_BIT_ACK], b[TCP_BIT_SYN], b[TCP_BIT_FIN]};
      end
    end

    if (!lst) begin
      if (frame_pos != 16'hFFFF) frame_pos = frame_pos + 16'd1;
      return 1'b0;
    end
    frame_pos = 16'd0;

    s.net_kind       = hdr_state.net_kind;
    s.transport_kind = hdr_state.transport_kind;
    s.src_hi         = hdr_state.src_hi;
    s.src_lo         = hdr_state.src_lo;
    s.dst_hi         = hdr_state.dst_hi;
    s.dst_lo         = hdr_state.dst_lo;
    if (hdr_state.transport_kind == TK_TCP || hdr_state.transport_kind == TK_UDP) begin
      s.src_port = hdr_state.src_port;
      s.dst_port = hdr_state.dst_port;
    end
    if (hdr_state.transport_kind == TK_TCP) begin
      s.seq_num   = hdr_state.seq_num;
      s.ack_num   = hdr_state.ack_num;
      s.tcp_flags = hdr_state.flags;
      // The port checks are tried in priority order: HTTP first, then FTP, then HTTPS.
      if (s.src_port == PORT_HTTP || s.dst_port == PORT_HTTP) s.app_kind = AK_HTTP;
      else if (s.src_port == PORT_FTP || s.dst_port == PORT_FTP) s.app_kind = AK_FTP;
      else if (s.src_port == PORT_HTTPS || s.dst_port == PORT_HTTPS) s.app_kind = AK_HTTPS;
    end else if (hdr_state.transport_kind == TK_UDP) begin
      if (s.src_port == PORT_DNS || s.dst_port == PORT_DNS) s.app_kind = AK_DNS;
    end
    return 1'b1;
  endfunction

  // Per-item wait. Mode 0 never waits. Mode 1 draws a uniform random wait for every item.
  // Mode 2 waits only now and then.
  function automatic int unsigned draw_gap(input int unsigned mode);
    if (mode == 0) return 0;
    if (mode == 1) return $urandom_range(0, 17);
    return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 17) : 0;
  endfunction

  function automatic logic [15:0] pick_port();
    case ($urandom_range(0, 7))
      0:       return PORT_HTTP;
      1:       return PORT_FTP;
      2:       return PORT_HTTPS;
      3:       return PORT_DNS;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic void put_byte(input int unsigned p, input logic [7:0] v);
    if (p < frame_bytes.size()) frame_bytes[p] = v;
  endfunction

  // Lays the recipe out as bytes over random filler. Any part beyond the frame length is
  // dropped. The layer-4 header is written first, so IPv4 header fields win where a short
  // IHL makes the two overlap.
  function automatic void lay_out_frame(input frame_recipe_t r);
    int unsigned l4;
    logic [111:0] l4_hdr;
    frame_bytes.delete();
    for (int unsigned i = 0; i < r.len; i++) begin
      frame_bytes.push_back(r.flat ? r.flat_val : 8'($urandom_range(0, 255)));
    end
    if (r.flat) return;
    l4 = (r.etype == ETH_TYPE_IPV6) ? 54 : 14 + 4 * r.ihl;
    l4_hdr = {r.sport, r.dport, r.seq, r.ack, 8'($urandom_range(0, 255)), r.flags};
    for (int unsigned i = 0; i < 14; i++) begin
      put_byte(l4 + i, l4_hdr[111 - 8 * i -: 8]);
    end
    put_byte(12, r.etype[15:8]);
    put_byte(13, r.etype[7:0]);
    if (r.etype == ETH_TYPE_IPV4) begin
      put_byte(14, {4'h4, r.ihl});
      put_byte(23, r.proto);
    end else if (r.etype == ETH_TYPE_IPV6) begin
      put_byte(20, r.proto);
    end
  endfunction

  // Random frame. Mostly known types and protocols with random content, plus unknown
  // codes, truncated frames and frames that run far past the captured headers.
  function automatic frame_recipe_t random_recipe();
    frame_recipe_t r;
    int unsigned pick;
    int unsigned l4;
    int unsigned full;
    r = '0;
    pick = $urandom_range(0, 99);
    if (pick < 30)      r.etype = ETH_TYPE_IPV4;
    else if (pick < 42) r.etype = ETH_TYPE_ARP;
    else if (pick < 50) r.etype = ETH_TYPE_RARP;
    else if (pick < 82) r.etype = ETH_TYPE_IPV6;
    else                r.etype = 16'($urandom_range(0, 65535));
    r.ihl = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 4)) : 4'($urandom_range(5, 15));
    pick = $urandom_range(0, 99);
    if (pick < 35)      r.proto = PROTO_TCP;
    else if (pick < 65) r.proto = PROTO_UDP;
    else if (pick < 75) r.proto = PROTO_ICMP;
    else if (pick < 85) r.proto = PROTO_IGMP;
    else                r.proto = 8'($urandom_range(0, 255));
    r.sport = pick_port();
    r.dport = pick_port();
    r.seq   = $urandom;
    r.ack   = $urandom;
    r.flags = 8'($urandom_range(0, 255));
    l4 = (r.etype == ETH_TYPE_IPV6) ? 54 : 14 + 4 * r.ihl;
    if (r.etype == ETH_TYPE_IPV6) full = 68;
    else if (r.etype == ETH_TYPE_ARP || r.etype == ETH_TYPE_RARP) full = 42;
    else full = (l4 + 14 > 34) ? l4 + 14 : 34;
    pick = $urandom_range(0, 99);
    if (pick < 70)      r.len = full + $urandom_range(0, 12);
    else if (pick < 92) r.len = $urandom_range(1, full);
    else                r.len = $urandom_range(129, 300);
    return r;
  endfunction

  // Sends one frame with the sender's own per-byte gaps. Each accepted byte also goes
  // through the predictor. The summary is queued on the transfer of the last byte.
  task automatic send_frame(input frame_recipe_t r);
    summary_t    s;
    int unsigned mode;
    int unsigned gap;
    int unsigned n;
    lay_out_frame(r);
    n = frame_bytes.size();
    mode = r.steady ? 0 : $urandom_range(0, 2);
    for (int unsigned i = 0; i < n; i++) begin
      gap = draw_gap(mode);
      if (gap > 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_chan.valid     <= 1'b1;
      in_chan.data_byte <= frame_bytes[i];
      in_chan.last_byte <= (i == n - 1);
      do @(posedge clk); while (in_chan.ready !== 1'b1);
      if (parse_byte(frame_bytes[i], i == n - 1, s)) begin
        if (r.typed) begin
          s = '0;
          s.net_kind = r.exp_nk;
        end
        summary_q.push_back(s);
        kind_seen[s.net_kind]++;
        if (s.transport_kind == TK_TCP) tcp_seen++;
        if (s.transport_kind == TK_UDP) udp_seen++;
        if (s.app_kind != AK_NONE) app_seen++;
      end
    end
    bytes_sent += n;
    frames_sent++;
  endtask

  // Main sequence: reset, the directed table, then random frames until enough bytes and
  // frames have gone through. Then drain the results and report.
  initial begin : run_frames
    int unsigned dir_bytes;
    int unsigned dir_frames;
    in_chan.valid     <= 1'b0;
    in_chan.data_byte <= 8'h00;
    in_chan.last_byte <= 1'b0;
    rst_n             <= 1'b0;
    frame_pos = 16'd0;
    hdr_state = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_DIR; i++) begin
      send_frame(dir_tab[i]);
    end
    dir_bytes  = bytes_sent;
    dir_frames = frames_sent;
    while (bytes_sent - dir_bytes < RAND_BYTES || frames_sent - dir_frames < RAND_FRAMES) begin
      send_frame(random_recipe());
    end
    in_chan.valid <= 1'b0;

    while (summary_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Covered %0d frames in %0d bytes: %0d IPv4, %0d ARP, %0d IPv6, %0d unknown type.",
             frames_sent, bytes_sent, kind_seen[NK_IPV4], kind_seen[NK_ARP],
             kind_seen[NK_IPV6], kind_seen[NK_NONE]);
    $display("Checked %0d summaries (%0d TCP, %0d UDP, %0d by port); %0d mismatches.",
             summaries_checked, tcp_seen, udp_seen, app_seen, mismatches);
    if (mismatches == 0) begin
      $display("tb_packet_header_parser: PASS");
    end else begin
      $display("tb_packet_header_parser: FAIL");
    end
    $finish;
  end

  // Result sink. It draws a stall for every summary. Once, it holds off for a long
  // stretch while the sender keeps offering frames. The parser then fills up and must
  // hold its input on the next last byte.
  initial begin : take_results
    int unsigned stall;
    int unsigned mode;
    int unsigned taken;
    out_chan.ready <= 1'b0;
    taken = 0;
    mode = 1;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (taken % 8 == 0) mode = $urandom_range(0, 2);
      stall = (taken == HOLD_AT) ? HOLD_CYCLES : draw_gap(mode);
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (out_chan.valid !== 1'b1);
      taken++;
    end
  end

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("Summary %0d: %s expected %h, got %h", summaries_checked, name, want, got);
      end
    end
  endfunction

  // Compares every summary transfer with the oldest predicted summary. It also counts
  // the cycles in which no transfer happens on either channel, for the watchdog.
  always @(posedge clk) begin : check_results
    summary_t want;
    if ((in_chan.valid === 1'b1 && in_chan.ready === 1'b1) ||
        (out_chan.valid === 1'b1 && out_chan.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (rst_n === 1'b1 && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      if (summary_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("Summary %0d arrived with no frame outstanding", summaries_checked);
        end
      end else begin
        want = summary_q.pop_front();
        check_field("net_kind",       want.net_kind,       out_chan.net_kind);
        check_field("transport_kind", want.transport_kind, out_chan.transport_kind);
        check_field("app_kind",       want.app_kind,       out_chan.app_kind);
        check_field("src_addr_hi",    want.src_hi,         out_chan.src_addr_hi);
        check_field("src_addr_lo",    want.src_lo,         out_chan.src_addr_lo);
        check_field("dst_addr_hi",    want.dst_hi,         out_chan.dst_addr_hi);
        check_field("dst_addr_lo",    want.dst_lo,         out_chan.dst_addr_lo);
        check_field("src_port",       want.src_port,       out_chan.src_port);
        check_field("dst_port",       want.dst_port,       out_chan.dst_port);
        check_field("seq_num",        want.seq_num,        out_chan.seq_num);
        check_field("ack_num",        want.ack_num,        out_chan.ack_num);
        check_field("tcp_flags",      want.tcp_flags,      out_chan.tcp_flags);
      end
      summaries_checked++;
    end
  end

  // Ends the run if neither channel has moved for far longer than any correct run stalls.
  initial begin : watchdog
    wait (idle_cycles >= STALL_LIMIT);
    $display("No transfer for %0d cycles, %0d summaries outstanding",
             STALL_LIMIT, summary_q.size());
    $display("tb_packet_header_parser: FAIL");
    $finish;
  end

endmodule
